/* src/rgbup_pkg.sv */
// Shared types, widths, codes and the per-channel blend for the 2x RGB upscaler.
// No dependencies; every other file refers to it by scoped names.
package rgbup_pkg;

  localparam int unsigned CfgW     = 11;
  localparam int unsigned CoordW   = 11;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned PixW     = 3 * ChanW;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [CfgW-1:0] WidthReset  = 11'd640;
  localparam logic [CfgW-1:0] HeightReset = 11'd480;

  typedef logic [PixW-1:0] pixel_t;
  // One source column of three rows: index 0 above, 1 centre, 2 below.
  typedef pixel_t [2:0] column_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  // (9*c + 3*h + 3*v + d + 8) >> 4 per channel; the sum stays below 4096.
  function automatic pixel_t mix(pixel_t c, pixel_t h, pixel_t v, pixel_t d);
    pixel_t      res;
    logic [11:0] cc;
    logic [11:0] hh;
    logic [11:0] vv;
    logic [11:0] dd;
    logic [11:0] sum;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      cc  = 12'(c[ch*ChanW +: ChanW]);
      hh  = 12'(h[ch*ChanW +: ChanW]);
      vv  = 12'(v[ch*ChanW +: ChanW]);
      dd  = 12'(d[ch*ChanW +: ChanW]);
      sum = (cc << 3) + cc + (hh << 1) + hh + (vv << 1) + vv + dd + 12'd8;
      res[ch*ChanW +: ChanW] = sum[11:4];
    end
    return res;
  endfunction

endpackage

/* src/rgbup_if.sv */
// Valid/ready channel interfaces for the upscaler's pixel input and result output.
// Depends on rgbup_pkg for field widths.
interface rgbup_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [rgbup_pkg::ChanW-1:0] in_red;
  logic [rgbup_pkg::ChanW-1:0] in_green;
  logic [rgbup_pkg::ChanW-1:0] in_blue;

  modport source (output valid, opcode, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, opcode, in_red, in_green, in_blue, output ready);
endinterface

interface rgbup_out_if;
  logic                         valid;
  logic                         ready;
  logic [rgbup_pkg::CoordW-1:0] out_x;
  logic [rgbup_pkg::CoordW-1:0] out_y;
  logic [rgbup_pkg::ChanW-1:0]  out_red;
  logic [rgbup_pkg::ChanW-1:0]  out_green;
  logic [rgbup_pkg::ChanW-1:0]  out_blue;
  logic                         frame_last;

  modport source (output valid, out_x, out_y, out_red, out_green, out_blue, frame_last,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_red, out_green, out_blue, frame_last,
                  output ready);
endinterface

/* src/rgb_image_upscale_2x_interpolate.sv */
// Top level of the 2x bilinear RGB upscaler: line stores, 3x3 window, result sequencer.
// Depends on rgbup_pkg and the channel interfaces in rgbup_if.sv.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------------
//  pix_i    | in        | valid/ready        | opcode, in_red, in_green, in_blue
//  pix_o    | out       | valid/ready        | out_x, out_y, out_red/green/blue, frame_last
//  APB      | in        | psel/penable/pwrite| paddr (reg index in bit 2), pwdata, prdata
//
// Each accepted pixel gives four results (eight at the end of a row, none on the first
// row, nor in the first column of an image wider than one pixel); the result sequencer
// sends one result a cycle unless pix_o stalls. An input is taken while earlier results
// still drain. An item passes the input stage, the sequencer and the result register.
// Reset clears counters, window and handshake state; the line stores are not cleared.
// A stall on pix_o holds the result register, then the sequencer, then the input stage.
module rgb_image_upscale_2x_interpolate #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rgbup_pkg::ApbAddrW-1:0]   paddr,
  input  logic [rgbup_pkg::ApbDataW-1:0]   pwdata,
  output logic [rgbup_pkg::ApbDataW-1:0]   prdata,
  output logic                             pready,
  rgbup_in_if.sink                         pix_i,
  rgbup_out_if.source                      pix_o
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);       // column index
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);   // holds the width itself
  localparam int unsigned RowW = $clog2(MAX_HEIGHT + 1);  // row count runs up to height

  typedef struct packed {
    rgbup_pkg::column_t left;
    rgbup_pkg::column_t mid;
    rgbup_pkg::column_t right;
    logic [ColW-1:0]    x;
    logic [RowW-1:0]    y;
    logic               last;
  } group_t;

  // ---------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------
  logic [rgbup_pkg::CfgW-1:0] image_width_q;
  logic [rgbup_pkg::CfgW-1:0] image_height_q;
  logic                       cfg_wr;
  rgbup_pkg::reg_idx_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = rgbup_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= rgbup_pkg::WidthReset;
      image_height_q <= rgbup_pkg::HeightReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rgbup_pkg::REG_IMAGE_WIDTH:  image_width_q  <= pwdata[rgbup_pkg::CfgW-1:0];
        rgbup_pkg::REG_IMAGE_HEIGHT: image_height_q <= pwdata[rgbup_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rgbup_pkg::REG_IMAGE_WIDTH:  prdata = rgbup_pkg::ApbDataW'(image_width_q);
      rgbup_pkg::REG_IMAGE_HEIGHT: prdata = rgbup_pkg::ApbDataW'(image_height_q);
      default:                     prdata = '0;
    endcase
  end

  // Effective size: zero acts as one, anything above the maximum as the maximum.
  logic [31:0]     w_raw;
  logic [31:0]     h_raw;
  logic [31:0]     w_eff32;
  logic [31:0]     h_eff32;
  logic [WW-1:0]   eff_w;
  logic [RowW-1:0] eff_h;

  assign w_raw = 32'(image_width_q);
  assign h_raw = 32'(image_height_q);

  always_comb begin
    if (w_raw == 32'd0)           w_eff32 = 32'd1;
    else if (w_raw > MAX_WIDTH)   w_eff32 = MAX_WIDTH;
    else                          w_eff32 = w_raw;
    if (h_raw == 32'd0)           h_eff32 = 32'd1;
    else if (h_raw > MAX_HEIGHT)  h_eff32 = MAX_HEIGHT;
    else                          h_eff32 = h_raw;
  end

  assign eff_w = w_eff32[WW-1:0];
  assign eff_h = h_eff32[RowW-1:0];

  // ---------------------------------------------------------------------------------
  // Position counters, advanced at accept time
  // ---------------------------------------------------------------------------------
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_cur;
  logic [RowW-1:0] row_cur;
  logic            in_drain;
  logic            in_live;     // item is neither a stray pixel nor an early drain
  logic            in_acc;
  logic            col_end;

  assign col_cur  = (WW'(col_q) >= eff_w) ? '0 : col_q;
  assign row_cur  = (row_q > eff_h) ? '0 : row_q;
  assign in_drain = (pix_i.opcode == rgbup_pkg::OP_DRAIN);
  assign in_live  = (row_cur < eff_h) != in_drain;
  assign in_acc   = pix_i.valid && pix_i.ready;
  assign col_end  = (WW'(col_cur) == eff_w - WW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_wr) begin
      // restart the frame; line stores keep their contents
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc && in_live) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= (row_cur >= eff_h) ? '0 : row_cur + RowW'(1);
      end else begin
        col_q <= col_cur + ColW'(1);
        row_q <= row_cur;
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Input stage: holds one item while its line-store read completes
  // ---------------------------------------------------------------------------------
  logic                s1_valid_q;
  logic [ColW-1:0]     s1_col_q;
  logic [RowW-1:0]     s1_row_q;
  rgbup_pkg::pixel_t   s1_pix_q;
  logic                s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc && in_live) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q <= col_cur;
      s1_row_q <= row_cur;
      s1_pix_q <= {pix_i.in_red, pix_i.in_green, pix_i.in_blue};
    end
  end

  assign pix_i.ready = !s1_valid_q || s1_move;

  // ---------------------------------------------------------------------------------
  // Line stores: read at accept, written when the item leaves the input stage
  // ---------------------------------------------------------------------------------
  rgbup_pkg::pixel_t older_mem [MAX_WIDTH];
  rgbup_pkg::pixel_t newer_mem [MAX_WIDTH];
  rgbup_pkg::pixel_t rd_older_q;
  rgbup_pkg::pixel_t rd_newer_q;
  rgbup_pkg::pixel_t fwd_older_q;
  rgbup_pkg::pixel_t fwd_newer_q;
  logic              fwd_q;
  rgbup_pkg::column_t cur;
  rgbup_pkg::pixel_t line_old;
  rgbup_pkg::pixel_t line_new;

  always_ff @(posedge clk_i) begin
    if (s1_move) older_mem[s1_col_q] <= cur[1];
    if (in_acc)  rd_older_q <= older_mem[col_cur];
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) newer_mem[s1_col_q] <= cur[2];
    if (in_acc)  rd_newer_q <= newer_mem[col_cur];
  end

  // A one-pixel-wide image reads the column being written in the same cycle: bypass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= s1_move && (s1_col_q == col_cur);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_older_q <= cur[1];
      fwd_newer_q <= cur[2];
    end
  end

  assign line_old = fwd_q ? fwd_older_q : rd_older_q;
  assign line_new = fwd_q ? fwd_newer_q : rd_newer_q;

  // Current column, rows r-2, r-1, r, clamped at the top and bottom edges.
  always_comb begin
    cur[1] = line_new;
    cur[0] = (s1_row_q >= RowW'(2)) ? line_old : line_new;
    cur[2] = (s1_row_q < eff_h) ? s1_pix_q : line_new;
  end

  // ---------------------------------------------------------------------------------
  // Window of the two previous columns and the groups that the item releases
  // ---------------------------------------------------------------------------------
  rgbup_pkg::column_t [1:0] win_q;   // [0] column c-2, [1] column c-1
  group_t                   grp_a;
  group_t                   grp_b;
  logic                     have_a;
  logic                     have_b;
  logic                     s1_col_end;

  assign s1_col_end = (WW'(s1_col_q) == eff_w - WW'(1));
  assign have_a     = (s1_row_q != '0) && (s1_col_q != '0);
  assign have_b     = (s1_row_q != '0) && s1_col_end;

  always_comb begin
    // left neighbour of the pixel one column back
    grp_a.left  = (s1_col_q >= ColW'(2)) ? win_q[0] : win_q[1];
    grp_a.mid   = win_q[1];
    grp_a.right = cur;
    grp_a.x     = s1_col_q - ColW'(1);
    grp_a.y     = s1_row_q - RowW'(1);
    grp_a.last  = 1'b0;
    // right edge of the row: the pixel itself, clamped on its right
    grp_b.left  = (s1_col_q != '0) ? win_q[1] : cur;
    grp_b.mid   = cur;
    grp_b.right = cur;
    grp_b.x     = s1_col_q;
    grp_b.y     = s1_row_q - RowW'(1);
    grp_b.last  = (s1_row_q == eff_h);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_move) begin
      win_q[0] <= win_q[1];
      win_q[1] <= cur;
    end
  end

  // ---------------------------------------------------------------------------------
  // Result sequencer: up to two 4-quadrant groups; unless pix_o stalls, one result a cycle
  // ---------------------------------------------------------------------------------
  group_t [1:0] grp_q;
  logic         s2_busy_q;
  logic         s2_sel_q;
  logic         s2_two_q;
  logic [1:0]   s2_quad_q;
  logic         s2_issue;
  logic         s2_final;
  logic         s2_free;
  logic         out_valid_q;

  assign s2_issue = s2_busy_q && (!out_valid_q || pix_o.ready);
  assign s2_final = (s2_quad_q == 2'd3) && (s2_sel_q || !s2_two_q);
  assign s2_free  = !s2_busy_q || (s2_issue && s2_final);
  assign s1_move  = s1_valid_q && s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_busy_q <= 1'b0;
      s2_sel_q  <= 1'b0;
      s2_two_q  <= 1'b0;
      s2_quad_q <= '0;
    end else if (s1_move) begin
      // load overrides the final advance of the previous item
      s2_busy_q <= have_a || have_b;
      s2_two_q  <= have_a && have_b;
      s2_sel_q  <= 1'b0;
      s2_quad_q <= '0;
    end else if (s2_issue) begin
      if (s2_final) begin
        s2_busy_q <= 1'b0;
      end else begin
        s2_quad_q <= s2_quad_q + 2'd1;
        if (s2_quad_q == 2'd3) s2_sel_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      grp_q[0] <= have_a ? grp_a : grp_b;
      grp_q[1] <= grp_b;
    end
  end

  // Blend for the current quadrant: dx picks the right side, dy the lower side.
  group_t             g;
  rgbup_pkg::column_t hcol;
  rgbup_pkg::pixel_t  blend;
  logic               dx;
  logic               dy;
  logic [31:0]        ox_wide;
  logic [31:0]        oy_wide;

  always_comb begin
    g       = grp_q[s2_sel_q];
    dx      = s2_quad_q[0];
    dy      = s2_quad_q[1];
    hcol    = dx ? g.right : g.left;
    blend   = rgbup_pkg::mix(g.mid[1], hcol[1],
                             dy ? g.mid[2] : g.mid[0],
                             dy ? hcol[2] : hcol[0]);
    ox_wide = 32'({g.x, dx});
    oy_wide = 32'({g.y, dy});
  end

  // ---------------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------------
  logic [rgbup_pkg::CoordW-1:0] out_x_q;
  logic [rgbup_pkg::CoordW-1:0] out_y_q;
  rgbup_pkg::pixel_t            out_rgb_q;
  logic                         frame_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_issue) begin
      out_valid_q <= 1'b1;
    end else if (pix_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_issue) begin
      out_x_q      <= ox_wide[rgbup_pkg::CoordW-1:0];
      out_y_q      <= oy_wide[rgbup_pkg::CoordW-1:0];
      out_rgb_q    <= blend;
      frame_last_q <= g.last && (s2_quad_q == 2'd3);
    end
  end

  assign pix_o.valid      = out_valid_q;
  assign pix_o.out_x      = out_x_q;
  assign pix_o.out_y      = out_y_q;
  assign pix_o.out_red    = out_rgb_q[2*rgbup_pkg::ChanW +: rgbup_pkg::ChanW];
  assign pix_o.out_green  = out_rgb_q[rgbup_pkg::ChanW +: rgbup_pkg::ChanW];
  assign pix_o.out_blue   = out_rgb_q[0 +: rgbup_pkg::ChanW];
  assign pix_o.frame_last = frame_last_q;

endmodule
